>>> design/divider_and_prescaled_timer_macros.svh
// Assertion macros shared by the timer checker.
`ifndef DIVIDER_AND_PRESCALED_TIMER_MACROS_SVH
`define DIVIDER_AND_PRESCALED_TIMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DPT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpt checker: same-cycle property violated");

// Next-cycle implication, sampled on clk, off during reset.
`define DPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpt checker: next-cycle property violated");

`endif

>>> design/dpt_pkg.sv
// Shared types, codes and helpers for the divider and prescaled timer.
package dpt_pkg;

	localparam int DATA_W  = 8;   // divider, timer, clocks, item data
	localparam int TSUB_W  = 10;  // timer prescale count, below 1024
	localparam int TSUM_W  = 11;  // prescale count plus one item's clocks
	localparam int NINC_W  = 7;   // pending increments, at most 79
	localparam int ADDR_W  = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] KIND_ADVANCE   = 2'd0;
	localparam logic [1:0] KIND_WRITE_DIV = 2'd1;
	localparam logic [1:0] KIND_WRITE_TMR = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_SELECT = 2'd1;
	localparam logic [1:0] REG_RELOAD = 2'd2;

	localparam logic [1:0] SEL_1024 = 2'd0;
	localparam logic [1:0] SEL_16   = 2'd1;
	localparam logic [1:0] SEL_64   = 2'd2;
	localparam logic [1:0] SEL_256  = 2'd3;

	typedef struct packed {
		logic                enable;
		logic [1:0]          select;
		logic [DATA_W-1:0]   reload;
	} dpt_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take the accepted item
		logic step;   // one timer stride (run or overflow)
		logic emit;   // move result into the output register
	} dpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;   // pending increments fit without overflow
		logic free;   // output register can take a result
	} dpt_stat_t;

	// log2 of the clocks per timer increment
	function automatic logic [3:0] tmr_shift(input logic [1:0] sel);
		logic [3:0] sh;
		unique case (sel)
			SEL_1024: sh = 4'd10;
			SEL_16:   sh = 4'd4;
			SEL_64:   sh = 4'd6;
			SEL_256:  sh = 4'd8;
			default:  sh = 4'd10;
		endcase
		return sh;
	endfunction

	function automatic logic [TSUM_W-1:0] tmr_mask(input logic [1:0] sel);
		logic [TSUM_W-1:0] m;
		unique case (sel)
			SEL_1024: m = 11'h3FF;
			SEL_16:   m = 11'h00F;
			SEL_64:   m = 11'h03F;
			SEL_256:  m = 11'h0FF;
			default:  m = 11'h3FF;
		endcase
		return m;
	endfunction

endpackage

>>> design/dpt_ctrl.sv
// Sequencing state machine: accept, run the timer strides, hand off the result.
module dpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dpt_pkg::dpt_stat_t stat,
	output dpt_pkg::dpt_cmd_t  cmd
);
	import dpt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} dpt_state_t;

	dpt_state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/dpt_datapath.sv
// Divider, timer, prescale counts and the output register.
module dpt_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dpt_pkg::dpt_cmd_t           cmd,
	output dpt_pkg::dpt_stat_t          stat,
	input  dpt_pkg::dpt_cfg_t           cfg,
	input  logic [1:0]                  kind,
	input  logic [dpt_pkg::DATA_W-1:0]  clocks,
	input  logic [dpt_pkg::DATA_W-1:0]  write_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [dpt_pkg::DATA_W-1:0]  divider_out,
	output logic [dpt_pkg::DATA_W-1:0]  timer_out,
	output logic                        irq_request
);
	import dpt_pkg::*;

	logic [DATA_W-1:0] div_q, div_sub_q, tmr_q;
	logic [TSUB_W-1:0] tmr_sub_q;
	logic [NINC_W-1:0] ninc_q;
	logic              irq_q, rsp_valid_q;

	logic [DATA_W-1:0] div_o_q, tmr_o_q;
	logic              irq_o_q;

	logic [DATA_W:0]   div_sum;
	logic [TSUM_W-1:0] tmr_sum;
	logic [NINC_W-1:0] ninc_new, ninc_left;
	logic [TSUB_W-1:0] tmr_rem;
	logic [DATA_W-1:0] room;

	always_comb begin
		div_sum   = {1'b0, div_sub_q} + {1'b0, clocks};
		tmr_sum   = {1'b0, tmr_sub_q} + {{(TSUM_W-DATA_W){1'b0}}, clocks};
		ninc_new  = NINC_W'(tmr_sum >> tmr_shift(cfg.select));
		tmr_rem   = TSUB_W'(tmr_sum & tmr_mask(cfg.select));
		room      = {DATA_W{1'b1}} - tmr_q;
		// only used on overflow, where room < ninc_q, so room fits
		ninc_left = ninc_q - room[NINC_W-1:0] - NINC_W'(1);
		stat.last = {{(DATA_W-NINC_W){1'b0}}, ninc_q} <= room;
		stat.free = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q     <= '0;
			div_sub_q <= '0;
			tmr_q     <= '0;
			tmr_sub_q <= '0;
			ninc_q    <= '0;
			irq_q     <= 1'b0;
		end else if (cmd.load) begin
			ninc_q <= '0;
			irq_q  <= 1'b0;
			unique case (kind)
				KIND_ADVANCE: begin
					div_sub_q <= div_sum[DATA_W-1:0];
					if (div_sum[DATA_W]) begin
						div_q <= div_q + DATA_W'(1);
					end
					if (cfg.enable) begin
						tmr_sub_q <= tmr_rem;
						ninc_q    <= ninc_new;
					end
				end
				KIND_WRITE_DIV: begin
					div_q <= write_data;
				end
				KIND_WRITE_TMR: begin
					tmr_q <= write_data;
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			if (stat.last) begin
				tmr_q  <= tmr_q + {{(DATA_W-NINC_W){1'b0}}, ninc_q};
				ninc_q <= '0;
			end else begin
				tmr_q  <= cfg.reload;
				ninc_q <= ninc_left;
				irq_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			div_o_q <= div_q;
			tmr_o_q <= tmr_q;
			irq_o_q <= irq_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign divider_out = div_o_q;
	assign timer_out   = tmr_o_q;
	assign irq_request = irq_o_q;

endmodule

>>> design/divider_and_prescaled_timer.sv
// Top level of the divider and prescaled timer: register port and block wiring.
//
// Request channel (req_valid/req_ready) carries one item: kind selects an
// advance by the clocks input, a divider load or a timer load from
// write_data. Each item gives exactly one result on the response channel
// (rsp_valid/rsp_ready): divider_out, timer_out and irq_request, the latter
// set when the timer wrapped at least once during the item.
// Timing: accept in IDLE, the timer unit runs one stride per cycle in RUN,
// then OUT writes the result to the output register. The result becomes
// valid as req_ready goes back high, so items are taken one at a time.
// Each timer wrap inside an advance costs one more stride; the worst case
// is a short period following a long held prescale count with reload 0xFF
// (up to 79 wraps).
// The output register decouples the two sides: a new item is accepted while
// a result still waits; if the receiver stalls, the next result is held in
// the unit until the register drains, and req_ready stays low meanwhile.
// Reset (arst_n low) clears divider, timer, both prescale counts and the
// three control registers; no result is pending afterwards.
// Registers on the APB-style port at byte offsets 0x0 enable, 0x4 clock
// select, 0x8 reload; write them only while no item is in flight.
module divider_and_prescaled_timer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   kind,
	input  logic [dpt_pkg::DATA_W-1:0]   clocks,
	input  logic [dpt_pkg::DATA_W-1:0]   write_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [dpt_pkg::DATA_W-1:0]   divider_out,
	output logic [dpt_pkg::DATA_W-1:0]   timer_out,
	output logic                         irq_request,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dpt_pkg::ADDR_W-1:0]   paddr,
	input  logic [dpt_pkg::PDATA_W-1:0]  pwdata,
	output logic [dpt_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import dpt_pkg::*;

	dpt_cfg_t   cfg_q;
	dpt_cmd_t   cmd;
	dpt_stat_t  stat;
	logic       wr_en;
	logic [1:0] reg_idx;

	// Register file: word index from the upper address bits, byte lanes ignored.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_SELECT: cfg_q.select <= pwdata[1:0];
				REG_RELOAD: cfg_q.reload <= pwdata[DATA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back; the unused slot reads as zero.
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.enable};
			REG_SELECT: prdata = {{(PDATA_W-2){1'b0}}, cfg_q.select};
			REG_RELOAD: prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.reload};
			default:    prdata = '0;
		endcase
	end

	dpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dpt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg_q),
		.kind        (kind),
		.clocks      (clocks),
		.write_data  (write_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.divider_out (divider_out),
		.timer_out   (timer_out),
		.irq_request (irq_request)
	);

endmodule

>>> design/dpt_checker.sv
// Port-level checker for the divider and prescaled timer, bound to the top level.
`include "divider_and_prescaled_timer_macros.svh"

module dpt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [dpt_pkg::DATA_W-1:0]   divider_out,
	input logic [dpt_pkg::DATA_W-1:0]   timer_out,
	input logic                         irq_request,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [dpt_pkg::ADDR_W-1:0]   paddr,
	input logic [dpt_pkg::PDATA_W-1:0]  pwdata,
	input logic                         pready
);
	import dpt_pkg::*;

	logic [1:0] cnt_q;   // items accepted, results not yet taken
	logic       en_q;    // shadow of the timer enable bit

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			en_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ENABLE) begin
				en_q <= pwdata[0];
			end
		end
	end

	`DPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(divider_out) && $stable(timer_out) && $stable(irq_request))
	`DPT_ASSERT_NEXT(a_one_item_busy, req_valid && req_ready, !req_ready)
	`DPT_ASSERT_NOW(a_irq_needs_enable, rsp_valid && irq_request, en_q)
	`DPT_ASSERT_NOW(a_rsp_has_item, rsp_valid, cnt_q != 2'd0 && cnt_q != 2'd3)

endmodule

bind divider_and_prescaled_timer dpt_checker u_dpt_checker (.*);

>>> tb/divider_and_prescaled_timer_tb.sv
// Self-checking testbench for the divider and prescaled timer block.
module divider_and_prescaled_timer_tb;

	import dpt_pkg::*;

	// Kind 3 is left undefined by the block; it must report without change.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned IDLE_PCT    = 18;
	localparam int unsigned PHASE_ITEMS = 210;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]        kind;
		logic [DATA_W-1:0] clocks;
		logic [DATA_W-1:0] write_data;
	} timer_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] divider;
		logic [DATA_W-1:0] timer;
		logic              irq;
	} timer_reading_t;

	typedef struct packed {
		logic              enable;
		logic [1:0]        select;
		logic [DATA_W-1:0] reload;
	} timer_setting_t;

	// ------------------------------------------------------------------
	// DUT connections
	// ------------------------------------------------------------------
	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic [1:0]          kind;
	logic [DATA_W-1:0]   clocks;
	logic [DATA_W-1:0]   write_data;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [DATA_W-1:0]   divider_out;
	logic [DATA_W-1:0]   timer_out;
	logic                irq_request;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	divider_and_prescaled_timer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.kind        (kind),
		.clocks      (clocks),
		.write_data  (write_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.divider_out (divider_out),
		.timer_out   (timer_out),
		.irq_request (irq_request),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the block: registers, counters and prescalers
	// ------------------------------------------------------------------
	logic              cfg_enable;
	logic [1:0]        cfg_select;
	logic [DATA_W-1:0] cfg_reload;

	logic [DATA_W-1:0] sh_divider;
	logic [DATA_W-1:0] sh_timer;
	logic [7:0]        sh_div_prescale;   // clocks towards next divider tick
	logic [TSUB_W-1:0] sh_tmr_prescale;   // clocks towards next timer tick

	timer_reading_t expected_readings_q[$];

	// Bookkeeping
	bit          calm_phase;     // no idling on either side while set
	int unsigned fault_count;
	int unsigned cycle_count;
	int unsigned advances_sent;
	int unsigned loads_sent;
	int unsigned unused_sent;
	int unsigned readings_checked;
	int unsigned irq_readings;
	int unsigned max_wraps;
	int unsigned settings_used;

	// ------------------------------------------------------------------
	// Clock, timeout
	// ------------------------------------------------------------------
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d readings outstanding",
				cycle_count, expected_readings_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// Predictor: applies one item to the shadow state and returns the
	// reading the block should give for it. Divider ticks on each
	// prescale carry, regardless of enable; the timer prescaler only
	// moves while enabled, keeps its count across disable and period
	// changes, so a shorter period can burst ticks on the next advance.
	// ------------------------------------------------------------------
	function automatic timer_reading_t compute_timer_reading(input timer_item_t it);
		timer_reading_t    r;
		logic [8:0]        div_sum;
		int unsigned       tmr_sum;
		int unsigned       period;
		int unsigned       wraps;

		r.irq = 1'b0;
		wraps = 0;
		case (it.kind)
			KIND_ADVANCE: begin
				advances_sent++;
				// it.clocks is 8 bits wide, so an item gives at most one divider tick
				div_sum = {1'b0, sh_div_prescale} + {1'b0, it.clocks};
				sh_div_prescale = div_sum[7:0];
				sh_divider = sh_divider + DATA_W'(div_sum[8]);
				if (cfg_enable) begin
					case (cfg_select)
						SEL_1024: period = 1024;
						SEL_16:   period = 16;
						SEL_64:   period = 64;
						default:  period = 256;
					endcase
					tmr_sum = sh_tmr_prescale + it.clocks;
					while (tmr_sum >= period) begin
						tmr_sum -= period;
						if (sh_timer == 8'hFF) begin
							sh_timer = cfg_reload;
							r.irq = 1'b1;
							wraps++;
						end else begin
							sh_timer = sh_timer + 8'd1;
						end
					end
					sh_tmr_prescale = TSUB_W'(tmr_sum);
				end
			end
			KIND_WRITE_DIV: begin
				loads_sent++;
				sh_divider = it.write_data;
			end
			KIND_WRITE_TMR: begin
				loads_sent++;
				sh_timer = it.write_data;
			end
			default: begin
				unused_sent++;
			end
		endcase
		if (wraps > max_wraps)
			max_wraps = wraps;
		r.divider = sh_divider;
		r.timer = sh_timer;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random back-pressure, and every accepted reading is
	// compared against the oldest prediction.
	// ------------------------------------------------------------------
	always @(negedge clk)
		rsp_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		timer_reading_t got;
		timer_reading_t want;

		if (arst_n && rsp_valid && rsp_ready) begin
			got.divider = divider_out;
			got.timer = timer_out;
			got.irq = irq_request;
			if (expected_readings_q.size() == 0) begin
				note_fault($sformatf("unexpected reading div=%02h tmr=%02h irq=%0b",
					got.divider, got.timer, got.irq));
			end else begin
				want = expected_readings_q.pop_front();
				readings_checked++;
				if (want.irq)
					irq_readings++;
				if (got.divider !== want.divider || got.timer !== want.timer ||
						got.irq !== want.irq)
					note_fault($sformatf(
						"reading mismatch: div %02h/%02h tmr %02h/%02h irq %0b/%0b (exp/act)",
						want.divider, got.divider, want.timer, got.timer,
						want.irq, got.irq));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers (all called and returning at a falling edge)
	// ------------------------------------------------------------------

	// Presents one item; valid stays up with the payload until taken.
	task automatic send_timer_item(input timer_item_t it);
		while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		kind = it.kind;
		clocks = it.clocks;
		write_data = it.write_data;
		do @(posedge clk); while (!req_ready);
		expected_readings_q.push_back(compute_timer_reading(it));
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] k, input logic [7:0] clk_count,
			input logic [7:0] data);
		timer_item_t it;

		it.kind = k;
		it.clocks = clk_count;
		it.write_data = data;
		send_timer_item(it);
	endtask

	// Holds the sender until every reading is in, plus a short margin.
	task automatic wait_drained();
		req_valid = 1'b0;
		while (expected_readings_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write then read-back of the same register. Caller keeps the
	// block idle.
	task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
		logic [PDATA_W-1:0] readback;

		req_valid = 1'b0;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = PDATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		case (idx)
			REG_ENABLE: cfg_enable = value[0];
			REG_SELECT: cfg_select = value[1:0];
			REG_RELOAD: cfg_reload = value;
			default: ;
		endcase
		// read back
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (readback !== PDATA_W'(value))
			note_fault($sformatf("register %0d read back %08h, wrote %08h",
				idx, readback, value));
	endtask

	task automatic apply_setting(input timer_setting_t s);
		wait_drained();
		write_register(REG_ENABLE, {7'd0, s.enable});
		write_register(REG_SELECT, {6'd0, s.select});
		write_register(REG_RELOAD, s.reload);
		settings_used++;
	endtask

	// Mostly advances with clock counts biased to the edges; timer loads
	// often land just below wrap so overflows come regularly.
	function automatic timer_item_t random_timer_item();
		timer_item_t it;
		int unsigned pick;

		it.clocks = $urandom_range(255);
		it.write_data = $urandom_range(255);
		pick = $urandom_range(99);
		if (pick < 78) begin
			it.kind = KIND_ADVANCE;
			case ($urandom_range(3))
				0: it.clocks = $urandom_range(15);
				1: it.clocks = $urandom_range(255, 240);
				default: ;
			endcase
		end else if (pick < 87) begin
			it.kind = KIND_WRITE_DIV;
		end else if (pick < 97) begin
			it.kind = KIND_WRITE_TMR;
			if ($urandom_range(1))
				it.write_data = $urandom_range(255, 240);
		end else begin
			it.kind = KIND_UNUSED;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Everything clear after reset; no clocks, and the unused kind.
	task automatic test_reset_state();
		send_fields(KIND_ADVANCE, 8'd0, 8'hFF);
		send_fields(KIND_UNUSED, 8'hFF, 8'hFF);
	endtask

	// Direct loads of both counters at their extremes; loads leave the
	// prescalers alone and never flag an interrupt.
	task automatic test_direct_loads();
		send_fields(KIND_WRITE_DIV, 8'h00, 8'hFF);
		send_fields(KIND_WRITE_TMR, 8'hFF, 8'hFF);
		send_fields(KIND_ADVANCE, 8'd255, 8'h00);  // prescale to 255, no tick
		send_fields(KIND_ADVANCE, 8'd1, 8'h00);    // divider wraps to zero
		send_fields(KIND_WRITE_TMR, 8'h00, 8'h00);
		send_fields(KIND_UNUSED, 8'h00, 8'h5A);
	endtask

	// Each period with the timer parked at 0xFF, reload at both ends.
	task automatic test_each_period();
		timer_setting_t s;

		for (int sel = 0; sel < 4; sel++) begin
			s.enable = 1'b1;
			s.select = 2'(sel);
			s.reload = sel[0] ? 8'hFF : 8'h00;
			apply_setting(s);
			send_fields(KIND_WRITE_TMR, 8'h00, 8'hFF);
			send_fields(KIND_ADVANCE, 8'd255, 8'h00);
		end
	endtask

	// Disabled timer holds its prescale count and resumes from it.
	task automatic test_disabled_hold();
		timer_setting_t s;

		s = '{enable: 1'b0, select: SEL_64, reload: 8'h10};
		apply_setting(s);
		send_fields(KIND_ADVANCE, 8'd200, 8'h00);
		s.enable = 1'b1;
		apply_setting(s);
		send_fields(KIND_ADVANCE, 8'd50, 8'h00);
	endtask

	// Build the prescale count up to 1023 on the long period, then switch
	// to the shortest one with reload 0xFF: worst-case burst of wraps.
	task automatic test_period_shortened();
		timer_setting_t s;
		int unsigned    gap;

		s = '{enable: 1'b1, select: SEL_1024, reload: 8'hFF};
		apply_setting(s);
		while (sh_tmr_prescale != 10'd1023) begin
			gap = 1023 - sh_tmr_prescale;
			send_fields(KIND_ADVANCE, (gap > 255) ? 8'd255 : 8'(gap), 8'h00);
		end
		s.select = SEL_16;
		apply_setting(s);
		send_fields(KIND_WRITE_TMR, 8'h00, 8'hFF);
		send_fields(KIND_ADVANCE, 8'd255, 8'h00);
	endtask

	// Random traffic over a sequence of settings. One phase runs with no
	// idling on either side; each phase pauses mid-way until drained.
	task automatic test_random_phases();
		timer_setting_t settings[8];

		settings[0] = '{enable: 1'b1, select: SEL_16,   reload: 8'hFF};
		settings[1] = '{enable: 1'b1, select: SEL_1024, reload: 8'h00};
		settings[2] = '{enable: 1'b0, select: SEL_64,   reload: 8'h80};
		settings[3] = '{enable: 1'b1, select: SEL_256,  reload: 8'hFF};
		settings[4] = '{enable: 1'b1, select: SEL_64,   reload: 8'h00};
		for (int p = 5; p < 8; p++) begin
			settings[p].enable = ($urandom_range(3) != 0);
			settings[p].select = 2'($urandom_range(3));
			settings[p].reload = 8'($urandom_range(255));
		end
		for (int p = 0; p < 8; p++) begin
			apply_setting(settings[p]);
			calm_phase = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				send_timer_item(random_timer_item());
			end
			calm_phase = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = KIND_ADVANCE;
		clocks = '0;
		write_data = '0;
		rsp_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm_phase = 1'b0;
		fault_count = 0;
		cycle_count = 0;
		advances_sent = 0;
		loads_sent = 0;
		unused_sent = 0;
		readings_checked = 0;
		irq_readings = 0;
		max_wraps = 0;
		settings_used = 0;
		cfg_enable = 1'b0;
		cfg_select = SEL_1024;
		cfg_reload = '0;
		sh_divider = '0;
		sh_timer = '0;
		sh_div_prescale = '0;
		sh_tmr_prescale = '0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_direct_loads();
		test_each_period();
		test_disabled_hold();
		test_period_shortened();
		test_random_phases();

		wait_drained();
		repeat (10) @(negedge clk);

		$display("Ran %0d advances, %0d counter loads, %0d unused-kind items over %0d settings",
			advances_sent, loads_sent, unused_sent, settings_used);
		$display("Checked %0d readings, %0d with interrupt, up to %0d wraps in one item",
			readings_checked, irq_readings, max_wraps);
		if (fault_count == 0 && expected_readings_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d faults, %0d readings never arrived",
				fault_count, expected_readings_q.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> divider_and_prescaled_timer.f
+incdir+design
design/dpt_pkg.sv
design/dpt_ctrl.sv
design/dpt_datapath.sv
design/divider_and_prescaled_timer.sv
design/dpt_checker.sv
tb/divider_and_prescaled_timer_tb.sv
